/* rtl/core/ismi_pkg.sv */
// Shared types and codes for the interval set merge/insert block.
`default_nettype none

package ismi_pkg;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_MOVE,
      ST_FINAL,
      ST_RESP
   } state_type;

   // Result status codes
   typedef enum logic [1:0] {
      STS_INSERTED = 2'd0,
      STS_MERGED   = 2'd1,
      STS_EMPTY    = 2'd2,
      STS_FULL     = 2'd3
   } status_type;

endpackage

`default_nettype wire

/* rtl/core/ismi_table.sv */
// Range table storage: one write port, one registered read port.
`default_nettype none

module ismi_table #(
   parameter int DEPTH = 16,
   parameter int DW    = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [DW-1:0]            wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [DW-1:0]            rd_data
);

   logic [DW-1:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* rtl/core/interval_set_merge_insert.sv */
// Top level: sorted interval set with merging insert.
// Keeps up to MAX_RANGES disjoint ranges [start,end) sorted by start in one
// table memory. Each word on req_ brings a range; ranges that overlap or touch
// it are folded into one entry, otherwise it is inserted in order unless the
// table is full. One word comes back on rsp_ per request, and a new request is
// taken only after the previous response has left. The scan reads the stored
// ranges one per cycle through the single read port and checks each word in
// the cycle after its read. A decide step follows. The entries behind the
// change are then moved, one read per cycle, each write trailing its read.
// A final write stores the range, and the response holds while rsp_stall is
// high. A full table with no overlap skips the move and the final write. An
// empty range is answered in the cycle after it is taken.
// The table needs no clearing pass: only entries below the count are read.
`default_nettype none

module interval_set_merge_insert #(
   parameter int MAX_RANGES   = 16,
   parameter int OFFSET_WIDTH = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [OFFSET_WIDTH-1:0]           req_range_start,
   input  wire logic [OFFSET_WIDTH-1:0]           req_range_end,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [OFFSET_WIDTH-1:0]                rsp_merged_start,
   output logic [OFFSET_WIDTH-1:0]                rsp_merged_end,
   output logic [$clog2(MAX_RANGES+1)-1:0]        rsp_stored_count,
   output logic [1:0]                             rsp_status
);

   import ismi_pkg::*;

   localparam int IW = $clog2(MAX_RANGES);
   localparam int CW = $clog2(MAX_RANGES + 1);
   localparam int OW = OFFSET_WIDTH;
   localparam int DW = 2 * OFFSET_WIDTH;

   state_type    state_ff, state_in;
   status_type   status_ff, status_in;
   logic [OW-1:0] ns_ff, ns_in, ne_ff, ne_in;
   logic [OW-1:0] ms_ff, ms_in, me_ff, me_in;
   logic [CW-1:0] count_ff, count_in, cnt_next_ff, cnt_next_in;
   logic [CW-1:0] scan_idx_ff, scan_idx_in, chk_idx_ff, chk_idx_in;
   logic          chk_vld_ff, chk_vld_in;
   logic          hit_ff, hit_in;
   logic [CW-1:0] first_ff, first_in, last_ff, last_in, pos_ff, pos_in;
   logic [CW-1:0] mv_src_ff, mv_src_in, mv_cnt_ff, mv_cnt_in, delta_ff, delta_in;
   logic          mv_up_ff, mv_up_in;
   logic [CW-1:0] fin_addr_ff, fin_addr_in;
   logic          pend_ff, pend_in;
   logic [CW-1:0] pend_dst_ff, pend_dst_in;

   logic          wr_en, rd_en;
   logic [IW-1:0] wr_addr, rd_addr;
   logic [DW-1:0] wr_data, rd_data;
   logic [OW-1:0] es, ee;
   logic          meet, req_acc, scan_done;

   ismi_table #(.DEPTH(MAX_RANGES), .DW(DW)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_acc   = req_valid && !req_stall;
   assign es        = rd_data[DW-1:OW];
   assign ee        = rd_data[OW-1:0];
   assign meet      = (es <= ns_ff) ? (ee >= ns_ff) : (ne_ff >= es);
   assign scan_done = (scan_idx_ff == count_ff) && !chk_vld_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in = (req_range_start >= req_range_end) ? ST_RESP : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!hit_ff && (count_ff == CW'(MAX_RANGES))) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_MOVE;
            end
         end
         ST_MOVE: begin
            if ((mv_cnt_ff == '0) && !pend_ff) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: state_in = ST_RESP;
         ST_RESP: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory control
   always_comb begin
      status_in   = status_ff;
      ns_in       = ns_ff;
      ne_in       = ne_ff;
      ms_in       = ms_ff;
      me_in       = me_ff;
      count_in    = count_ff;
      cnt_next_in = cnt_next_ff;
      scan_idx_in = scan_idx_ff;
      chk_idx_in  = chk_idx_ff;
      chk_vld_in  = 1'b0;
      hit_in      = hit_ff;
      first_in    = first_ff;
      last_in     = last_ff;
      pos_in      = pos_ff;
      mv_src_in   = mv_src_ff;
      mv_cnt_in   = mv_cnt_ff;
      delta_in    = delta_ff;
      mv_up_in    = mv_up_ff;
      fin_addr_in = fin_addr_ff;
      pend_in     = 1'b0;
      pend_dst_in = pend_dst_ff;
      rd_en       = 1'b0;
      rd_addr     = '0;
      wr_en       = 1'b0;
      wr_addr     = pend_dst_ff[IW-1:0];
      wr_data     = rd_data;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               ns_in       = req_range_start;
               ne_in       = req_range_end;
               scan_idx_in = '0;
               hit_in      = 1'b0;
               first_in    = '0;
               last_in     = '0;
               pos_in      = '0;
               if (req_range_start >= req_range_end) begin
                  ms_in     = '0;
                  me_in     = '0;
                  status_in = STS_EMPTY;
               end else begin
                  ms_in = req_range_start;
                  me_in = req_range_end;
               end
            end
         end
         ST_SCAN: begin
            // issue one read per cycle
            if (scan_idx_ff != count_ff) begin
               rd_en       = 1'b1;
               rd_addr     = scan_idx_ff[IW-1:0];
               chk_vld_in  = 1'b1;
               chk_idx_in  = scan_idx_ff;
               scan_idx_in = scan_idx_ff + 1'b1;
            end
            // check the word read last cycle
            if (chk_vld_ff) begin
               if (es < ns_ff) begin
                  pos_in = pos_ff + 1'b1;
               end
               if (meet) begin
                  if (!hit_ff) begin
                     first_in = chk_idx_ff;
                  end
                  hit_in  = 1'b1;
                  last_in = chk_idx_ff + 1'b1;
                  if (es < ms_ff) begin
                     ms_in = es;
                  end
                  if (ee > me_ff) begin
                     me_in = ee;
                  end
               end
            end
         end
         ST_DECIDE: begin
            if (hit_ff) begin
               // pull entries behind the merged run down
               status_in   = STS_MERGED;
               mv_up_in    = 1'b0;
               mv_src_in   = last_ff;
               mv_cnt_in   = count_ff - last_ff;
               delta_in    = last_ff - first_ff - 1'b1;
               fin_addr_in = first_ff;
               cnt_next_in = count_ff - (last_ff - first_ff) + 1'b1;
               if (last_ff - first_ff == CW'(1)) begin
                  mv_cnt_in = '0;
               end
            end else if (count_ff == CW'(MAX_RANGES)) begin
               status_in = STS_FULL;
               ms_in     = '0;
               me_in     = '0;
            end else begin
               // open a slot at the insert position
               status_in   = STS_INSERTED;
               mv_up_in    = 1'b1;
               mv_src_in   = count_ff - 1'b1;
               mv_cnt_in   = count_ff - pos_ff;
               delta_in    = '0;
               fin_addr_in = pos_ff;
               cnt_next_in = count_ff + 1'b1;
            end
         end
         ST_MOVE: begin
            if (mv_cnt_ff != '0) begin
               rd_en       = 1'b1;
               rd_addr     = mv_src_ff[IW-1:0];
               pend_in     = 1'b1;
               pend_dst_in = mv_up_ff ? (mv_src_ff + 1'b1) : (mv_src_ff - delta_ff);
               mv_src_in   = mv_up_ff ? (mv_src_ff - 1'b1) : (mv_src_ff + 1'b1);
               mv_cnt_in   = mv_cnt_ff - 1'b1;
            end
            if (pend_ff) begin
               wr_en = 1'b1;
            end
         end
         ST_FINAL: begin
            wr_en    = 1'b1;
            wr_addr  = fin_addr_ff[IW-1:0];
            wr_data  = {ms_ff, me_ff};
            count_in = cnt_next_ff;
         end
         ST_RESP: begin
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         chk_vld_ff <= 1'b0;
         pend_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         chk_vld_ff <= chk_vld_in;
         pend_ff    <= pend_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      status_ff   <= status_in;
      ns_ff       <= ns_in;
      ne_ff       <= ne_in;
      ms_ff       <= ms_in;
      me_ff       <= me_in;
      cnt_next_ff <= cnt_next_in;
      scan_idx_ff <= scan_idx_in;
      chk_idx_ff  <= chk_idx_in;
      hit_ff      <= hit_in;
      first_ff    <= first_in;
      last_ff     <= last_in;
      pos_ff      <= pos_in;
      mv_src_ff   <= mv_src_in;
      mv_cnt_ff   <= mv_cnt_in;
      delta_ff    <= delta_in;
      mv_up_ff    <= mv_up_in;
      fin_addr_ff <= fin_addr_in;
      pend_dst_ff <= pend_dst_in;
   end

   // Handshake and result word
   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = (state_ff == ST_RESP);
   assign rsp_merged_start = ms_ff;
   assign rsp_merged_end   = me_ff;
   assign rsp_stored_count = count_ff;
   assign rsp_status       = status_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_RANGES))
      else $error("range count beyond table depth");

   a_empty_fast: assert property (@(posedge clock) disable iff (reset)
      (req_acc && (req_range_start >= req_range_end))
      |=> (rsp_valid && (rsp_status == STS_EMPTY)))
      else $error("empty range not rejected at once");

   a_scan_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |=> $stable(count_ff))
      else $error("count changed during scan");

   a_merged_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ((rsp_status == STS_MERGED) || (rsp_status == STS_INSERTED)))
      |-> (ms_ff < me_ff))
      else $error("stored range not ordered");

endmodule

`default_nettype wire
